FILE: rtl/mmpc_pkg.sv
package mmpc_pkg;

  // Fixed field widths of the voxel and pixel payloads.
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned MAX_DEPTH_DEF = 256;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  // Offsets are Q16.16 while mean * gain is Q.24, so the offset moves up by 8 bits.
  localparam int unsigned FRAC_SHIFT = 8;
  // Bit position of 1.0 in the Q.24 mapped value.
  localparam int unsigned ONE_POS    = 24;

  localparam logic signed [COEF_W-1:0] OFFSET_RESET = 32'sd0;
  localparam logic signed [COEF_W-1:0] GAIN_RESET   = 32'sd65536;
  localparam logic [COLOR_W-1:0]       VOID_RESET   = 24'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_OFFSET   = 3'd0,
    REG_RED_GAIN     = 3'd1,
    REG_GREEN_OFFSET = 3'd2,
    REG_GREEN_GAIN   = 3'd3,
    REG_BLUE_OFFSET  = 3'd4,
    REG_BLUE_GAIN    = 3'd5,
    REG_VOID_COLOUR  = 3'd6
  } cfg_reg_e;

  typedef logic [1:0] ch_idx_t;
  localparam ch_idx_t CH_RED   = 2'd0;
  localparam ch_idx_t CH_GREEN = 2'd1;
  localparam ch_idx_t CH_BLUE  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] red_sample;
    logic signed [SAMPLE_BITS-1:0] green_sample;
    logic signed [SAMPLE_BITS-1:0] blue_sample;
    logic                          is_tissue;
    logic                          column_end;
  } voxel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             is_void;
  } pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accum;
    logic    div_start;
    logic    mul;
    logic    map;
    logic    out_load;
    ch_idx_t ch;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic div_done;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: rtl/mmpc_div.sv
module mmpc_div #(
  parameter int unsigned DVD_W = 25,
  parameter int unsigned DVS_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign quot_o = quo_q;

endmodule

FILE: rtl/mmpc_dp.sv
module mmpc_dp #(
  parameter int unsigned MAX_DEPTH = mmpc_pkg::MAX_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmpc_pkg::voxel_t                    in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [mmpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mmpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  mmpc_pkg::ctrl_cmd_t                 cmd_i,
  output mmpc_pkg::ctrl_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mmpc_pkg::pixel_t                    out_data_o
);

  localparam int unsigned SB     = mmpc_pkg::SAMPLE_BITS;
  localparam int unsigned CW     = mmpc_pkg::COEF_W;
  localparam int unsigned NCH    = mmpc_pkg::NUM_CH;
  localparam int unsigned PW     = mmpc_pkg::PIX_W;
  localparam int unsigned ONE    = mmpc_pkg::ONE_POS;
  localparam int unsigned FS     = mmpc_pkg::FRAC_SHIFT;
  localparam int unsigned CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned TOT_W  = SB + $clog2(MAX_DEPTH) + 1;
  localparam int unsigned PROD_W = SB + CW;
  localparam int unsigned V_W    = PROD_W + 1;
  localparam int unsigned SC_W   = ONE + PW + 1;
  localparam logic [V_W-1:0]  ONE_V   = {{(V_W-ONE-1){1'b0}}, 1'b1, {ONE{1'b0}}};
  localparam logic [SC_W-1:0] HALF_SC = {{(PW+1){1'b0}}, 1'b1, {(ONE-1){1'b0}}};

  // Configuration registers.
  logic signed [CW-1:0]             offset_q [NCH];
  logic signed [CW-1:0]             gain_q   [NCH];
  logic [mmpc_pkg::COLOR_W-1:0]     void_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        offset_q[i] <= mmpc_pkg::OFFSET_RESET;
        gain_q[i]   <= mmpc_pkg::GAIN_RESET;
      end
      void_q <= mmpc_pkg::VOID_RESET;
    end else if (cfg_valid_i) begin
      unique case (mmpc_pkg::cfg_reg_e'(cfg_idx_i))
        mmpc_pkg::REG_RED_OFFSET:   offset_q[mmpc_pkg::CH_RED]   <= cfg_data_i;
        mmpc_pkg::REG_RED_GAIN:     gain_q[mmpc_pkg::CH_RED]     <= cfg_data_i;
        mmpc_pkg::REG_GREEN_OFFSET: offset_q[mmpc_pkg::CH_GREEN] <= cfg_data_i;
        mmpc_pkg::REG_GREEN_GAIN:   gain_q[mmpc_pkg::CH_GREEN]   <= cfg_data_i;
        mmpc_pkg::REG_BLUE_OFFSET:  offset_q[mmpc_pkg::CH_BLUE]  <= cfg_data_i;
        mmpc_pkg::REG_BLUE_GAIN:    gain_q[mmpc_pkg::CH_BLUE]    <= cfg_data_i;
        mmpc_pkg::REG_VOID_COLOUR:  void_q <= cfg_data_i[mmpc_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Column accumulators.
  logic signed [SB-1:0]    sample [NCH];
  logic signed [TOT_W-1:0] tot_q  [NCH];
  logic [CNT_W-1:0]        count_q;
  logic                    take;

  assign sample[mmpc_pkg::CH_RED]   = in_data_i.red_sample;
  assign sample[mmpc_pkg::CH_GREEN] = in_data_i.green_sample;
  assign sample[mmpc_pkg::CH_BLUE]  = in_data_i.blue_sample;
  assign take = cmd_i.accum && in_data_i.is_tissue && (count_q < CNT_W'(MAX_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        tot_q[i] <= '0;
      end
      count_q <= '0;
    end else if (cmd_i.out_load) begin
      for (int i = 0; i < NCH; i++) begin
        tot_q[i] <= '0;
      end
      count_q <= '0;
    end else if (take) begin
      for (int i = 0; i < NCH; i++) begin
        tot_q[i] <= tot_q[i] + {{(TOT_W-SB){sample[i][SB-1]}}, sample[i]};
      end
      count_q <= count_q + CNT_W'(1);
    end
  end

  // Mean by sign and magnitude through the serial divider.
  logic signed [TOT_W-1:0] tot_sel;
  logic [TOT_W-1:0]        mag;
  logic                    neg_q;
  logic [TOT_W-1:0]        quot;
  logic [TOT_W-1:0]        quot_s;
  logic signed [SB-1:0]    mean;
  logic                    div_done;

  assign tot_sel = tot_q[cmd_i.ch];
  assign mag     = tot_sel[TOT_W-1] ? -tot_sel : tot_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= tot_sel[TOT_W-1];
    end
  end

  mmpc_div #(
    .DVD_W (TOT_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign quot_s = neg_q ? -quot : quot;
  assign mean   = quot_s[SB-1:0];

  // Gain multiply, registered before the offset add.
  logic signed [CW-1:0]     gain_sel;
  logic signed [CW-1:0]     off_sel;
  logic signed [PROD_W-1:0] prod_q;

  assign gain_sel = gain_q[cmd_i.ch];
  assign off_sel  = offset_q[cmd_i.ch];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {{CW{mean[SB-1]}}, mean} * {{SB{gain_sel[CW-1]}}, gain_sel};
    end
  end

  // Offset add, clamp to [0, 1.0] and round to 8 bits.
  logic signed [V_W-1:0] v;
  logic [ONE:0]          clamped;
  logic [SC_W-1:0]       scaled;
  logic [PW-1:0]         pix_byte;
  logic [PW-1:0]         bytes_q [NCH];

  assign v = {{(V_W-CW-FS){off_sel[CW-1]}}, off_sel, {FS{1'b0}}}
           + {prod_q[PROD_W-1], prod_q};

  always_comb begin
    if (v[V_W-1]) begin
      clamped = '0;
    end else if (v > ONE_V) begin
      clamped = ONE_V[ONE:0];
    end else begin
      clamped = v[ONE:0];
    end
  end

  // v * 255 written as v * 256 - v.
  assign scaled   = {clamped, {PW{1'b0}}} - {{PW{1'b0}}, clamped} + HALF_SC;
  assign pix_byte = scaled[ONE+PW-1:ONE];

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      bytes_q[cmd_i.ch] <= pix_byte;
    end
  end

  // Output register.
  logic             out_valid_q;
  mmpc_pkg::pixel_t out_q;
  logic             count_zero;

  assign count_zero = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (count_zero) begin
        out_q.red_out   <= void_q[3*PW-1:2*PW];
        out_q.green_out <= void_q[2*PW-1:PW];
        out_q.blue_out  <= void_q[PW-1:0];
        out_q.is_void   <= 1'b1;
      end else begin
        out_q.red_out   <= bytes_q[mmpc_pkg::CH_RED];
        out_q.green_out <= bytes_q[mmpc_pkg::CH_GREEN];
        out_q.blue_out  <= bytes_q[mmpc_pkg::CH_BLUE];
        out_q.is_void   <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.count_zero = count_zero;
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // The tissue count saturates at the column depth limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_DEPTH))
    else $error("tissue count beyond depth limit");

endmodule

FILE: rtl/mmpc_ctrl.sv
module mmpc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   column_end_i,
  output logic                   in_ready_o,
  input  mmpc_pkg::ctrl_status_t status_i,
  output mmpc_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_ACCUM = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_MAP   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  mmpc_pkg::ch_idx_t ch_q, ch_d;

  always_comb begin
    state_d       = state_q;
    ch_d          = ch_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.ch      = ch_q;
    unique case (state_q)
      S_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          if (column_end_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_d = status_i.count_zero ? S_FIN : S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_MAP;
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        if (ch_q == mmpc_pkg::CH_BLUE) begin
          state_d = S_FIN;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = S_LOAD;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          ch_d           = mmpc_pkg::CH_RED;
          state_d        = S_ACCUM;
        end
      end
      default: state_d = S_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCUM;
      ch_q    <= mmpc_pkg::CH_RED;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // A column's last voxel stops the input until its pixel is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && column_end_i |=> !in_ready_o)
    else $error("input accepted right after end of column");

  // Every product is followed by its mapping step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |=> cmd_o.map && $stable(ch_q))
    else $error("multiply not followed by map on same channel");

  // The channel index only takes the three channel codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q == mmpc_pkg::CH_RED || ch_q == mmpc_pkg::CH_GREEN || ch_q == mmpc_pkg::CH_BLUE)
    else $error("channel index out of range");

endmodule

FILE: rtl/masked_mean_projection_colormap_core.sv
// Masked mean projection with a linear color map. Voxels of one pixel's depth column arrive
// one transaction at a time; tissue voxels add their three Q8.8 channel samples into running
// totals and bump a tissue count, which saturates at MAX_DEPTH (later tissue voxels of that
// column are ignored). The voxel flagged column_end closes the column and yields one pixel:
// per channel, clamp(offset + mean * gain) to [0, 1.0] scaled to 0..255 with rounding, the
// mean being the total divided by the count, truncated toward zero. A column without tissue
// returns the background color with is_void set. Throughput: one voxel per clock while a
// column accumulates. After the column_end voxel the input stays closed while the pixel is
// worked out. A column without tissue skips the divider; otherwise the single serial
// divider, which yields one quotient bit per clock, is shared by the three channels in
// turn, each followed by a multiply step and a map step. A pixel waiting in the output
// register does not hold off the next column's voxels; only queuing the following pixel
// waits for it to drain. Configuration writes are always ready and should be issued only
// while no column is in progress.
module masked_mean_projection_colormap_core #(
  parameter int unsigned MAX_DEPTH = mmpc_pkg::MAX_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // Voxel input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mmpc_pkg::voxel_t                in_data_i,

  // Pixel output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mmpc_pkg::pixel_t                out_data_o,

  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mmpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mmpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mmpc_pkg::ctrl_cmd_t    cmd;
  mmpc_pkg::ctrl_status_t status;

  // Register writes land directly in the configuration registers, so the configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  // The controller sequences accumulation, the per-channel divide, multiply and map
  // steps, and the hand-off of the finished pixel into the output register.
  mmpc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .column_end_i (in_data_i.column_end),
    .in_ready_o   (in_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // The datapath holds the registers, accumulators, divider, multiplier and the
  // output register.
  mmpc_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
